>>> src/sep_pkg.sv
package sep_pkg;

    // fixed lengths
    localparam int unsigned MAGIC_LEN  = 4;
    localparam int unsigned PARENT_LEN = 36;

    // opcodes
    localparam logic [7:0] OPC_RETURN = 8'h6a;
    localparam logic [7:0] OPC_PD1    = 8'h4c;
    localparam logic [7:0] OPC_PD2    = 8'h4d;
    localparam logic [7:0] OPC_PD4    = 8'h4e;

    // parse phases
    localparam logic [3:0] PH_RET   = 4'd0;
    localparam logic [3:0] PH_NOT   = 4'd1;
    localparam logic [3:0] PH_MOP   = 4'd2;
    localparam logic [3:0] PH_MLEN  = 4'd3;
    localparam logic [3:0] PH_MDATA = 4'd4;
    localparam logic [3:0] PH_OP    = 4'd5;
    localparam logic [3:0] PH_LEN   = 4'd6;
    localparam logic [3:0] PH_DATA  = 4'd7;
    localparam logic [3:0] PH_BAD   = 4'd8;

    // byte classes
    localparam logic [3:0] CLS_HEADER   = 4'd0;
    localparam logic [3:0] CLS_CTYPE    = 4'd1;
    localparam logic [3:0] CLS_PARENT   = 4'd2;
    localparam logic [3:0] CLS_METADATA = 4'd3;
    localparam logic [3:0] CLS_METAPROT = 4'd4;
    localparam logic [3:0] CLS_ENCODING = 4'd5;
    localparam logic [3:0] CLS_DELEGATE = 4'd6;
    localparam logic [3:0] CLS_BODY     = 4'd7;
    localparam logic [3:0] CLS_IGNORED  = 4'd8;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NOT_ENV    = 3'd1;
    localparam logic [2:0] ERR_MALFORMED  = 3'd2;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
    localparam logic [2:0] ERR_DUPLICATE  = 3'd4;
    localparam logic [2:0] ERR_BAD_PARENT = 3'd5;
    localparam logic [2:0] ERR_UNKNOWN    = 3'd6;

    // register indexes
    localparam logic [2:0] REG_MAGIC    = 3'd0;
    localparam logic [2:0] REG_CTYPE    = 3'd1;
    localparam logic [2:0] REG_PARENT   = 3'd2;
    localparam logic [2:0] REG_METADATA = 3'd3;
    localparam logic [2:0] REG_METAPROT = 3'd4;
    localparam logic [2:0] REG_ENCODING = 3'd5;
    localparam logic [2:0] REG_DELEGATE = 3'd6;
    localparam logic [2:0] REG_IGNORE   = 3'd7;

    localparam logic [31:0] MAGIC_RESET = 32'd1145980500;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  content_type_tag;
        logic [7:0]  parent_tag;
        logic [7:0]  metadata_tag;
        logic [7:0]  metaprotocol_tag;
        logic [7:0]  encoding_tag;
        logic [7:0]  delegate_tag;
        logic [7:0]  ignore_tag;
    } sep_cfg_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [3:0] byte_class;
        logic       script_done;
        logic       env_found;
        logic       envelope_valid;
        logic [2:0] error_code;
        logic       body_seen;
        logic [7:0] parent_count;
    } sep_result_t;

endpackage

>>> src/sep_cfg_regs.sv
module sep_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output sep_pkg::sep_cfg_t cfg
);

    sep_pkg::sep_cfg_t cfg_reg;
    sep_pkg::sep_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                sep_pkg::REG_MAGIC:    cfg_next.magic_word       = cfg_data;
                sep_pkg::REG_CTYPE:    cfg_next.content_type_tag = cfg_data[7:0];
                sep_pkg::REG_PARENT:   cfg_next.parent_tag       = cfg_data[7:0];
                sep_pkg::REG_METADATA: cfg_next.metadata_tag     = cfg_data[7:0];
                sep_pkg::REG_METAPROT: cfg_next.metaprotocol_tag = cfg_data[7:0];
                sep_pkg::REG_ENCODING: cfg_next.encoding_tag     = cfg_data[7:0];
                sep_pkg::REG_DELEGATE: cfg_next.delegate_tag     = cfg_data[7:0];
                sep_pkg::REG_IGNORE:   cfg_next.ignore_tag       = cfg_data[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word       <= sep_pkg::MAGIC_RESET;
            cfg_reg.content_type_tag <= 8'd1;
            cfg_reg.parent_tag       <= 8'd3;
            cfg_reg.metadata_tag     <= 8'd5;
            cfg_reg.metaprotocol_tag <= 8'd7;
            cfg_reg.encoding_tag     <= 8'd9;
            cfg_reg.delegate_tag     <= 8'd11;
            cfg_reg.ignore_tag       <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/sep_parser.sv
module sep_parser #(
    parameter int unsigned PARENT_LEN = sep_pkg::PARENT_LEN
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           script_byte,
    input  logic                 last_byte,
    input  sep_pkg::sep_cfg_t    cfg,
    output sep_pkg::sep_result_t result
);

    typedef struct packed {
        logic [3:0]  phase;
        logic [31:0] push_remaining;
        logic [2:0]  length_bytes_left;
        logic [1:0]  len_pos;
        logic [31:0] magic_shift;
        logic        push_index_odd;
        logic        in_body;
        logic [8:0]  current_tag;
        logic [3:0]  current_class;
        logic [3:0]  seen_singles;
        logic [7:0]  parents_seen;
        logic [2:0]  first_field_error;
        logic        malformed_flag;
        logic        first_data;
        logic        parent_ok;
    } state_t;

    state_t state_reg;
    state_t state_next;

    function automatic state_t field_error(input state_t s, input logic [2:0] code);
        state_t r;
        r = s;
        if (r.first_field_error == sep_pkg::ERR_NONE) r.first_field_error = code;
        return r;
    endfunction

    function automatic state_t single_field(input state_t s, input logic [3:0] cls,
                                            input logic [1:0] bit_idx);
        state_t r;
        r = s;
        r.current_class = cls;
        if (r.seen_singles[bit_idx]) r = field_error(r, sep_pkg::ERR_DUPLICATE);
        else r.seen_singles[bit_idx] = 1'b1;
        return r;
    endfunction

    function automatic state_t tag_finish(input state_t s, input sep_pkg::sep_cfg_t c);
        state_t     r;
        logic [7:0] t;
        logic       known;
        r     = s;
        t     = s.current_tag[7:0];
        known = 1'b1;
        if (!s.current_tag[8]) known = 1'b0;
        else if (t == c.content_type_tag) r = single_field(r, sep_pkg::CLS_CTYPE, 2'd0);
        else if (t == c.parent_tag) r.current_class = sep_pkg::CLS_PARENT;
        else if (t == c.metadata_tag) r.current_class = sep_pkg::CLS_METADATA;
        else if (t == c.metaprotocol_tag) r = single_field(r, sep_pkg::CLS_METAPROT, 2'd1);
        else if (t == c.encoding_tag) r = single_field(r, sep_pkg::CLS_ENCODING, 2'd2);
        else if (t == c.delegate_tag) r = single_field(r, sep_pkg::CLS_DELEGATE, 2'd3);
        else if (t == c.ignore_tag) r.current_class = sep_pkg::CLS_IGNORED;
        else known = 1'b0;
        if (!known) begin
            r.current_class = sep_pkg::CLS_IGNORED;
            if (!t[0]) r = field_error(r, sep_pkg::ERR_UNKNOWN);
        end
        return r;
    endfunction

    function automatic state_t push_finish(input state_t s, input sep_pkg::sep_cfg_t c);
        state_t r;
        r = s;
        if (!s.in_body) begin
            if (!s.push_index_odd) begin
                r = tag_finish(r, c);
                r.push_index_odd = 1'b1;
            end else begin
                if (s.parent_ok && s.first_field_error == sep_pkg::ERR_NONE &&
                    s.parents_seen != 8'hff) begin
                    r.parents_seen = s.parents_seen + 8'd1;
                end
                r.parent_ok      = 1'b0;
                r.push_index_odd = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic state_t push_begin(input state_t s, input logic [31:0] n,
                                          input sep_pkg::sep_cfg_t c);
        state_t r;
        r = s;
        r.parent_ok = 1'b0;
        if (s.in_body) begin
            r.current_class = sep_pkg::CLS_BODY;
        end else if (!s.push_index_odd) begin
            r.current_class = sep_pkg::CLS_HEADER;
            if (n == 32'd0) r.in_body = 1'b1;
            else r.current_tag = (n == 32'd1) ? 9'h100 : 9'h000;
        end else if (s.current_class == sep_pkg::CLS_PARENT) begin
            if (n != 32'(PARENT_LEN)) r = field_error(r, sep_pkg::ERR_BAD_PARENT);
            else r.parent_ok = 1'b1;
        end
        if (n == 32'd0) begin
            r       = push_finish(r, c);
            r.phase = sep_pkg::PH_OP;
        end else begin
            r.push_remaining = n;
            r.first_data     = 1'b1;
            r.phase          = sep_pkg::PH_DATA;
        end
        return r;
    endfunction

    function automatic state_t length_setup(input state_t s, input logic [7:0] opc,
                                            input logic [3:0] next_phase);
        state_t r;
        r = s;
        if (opc == sep_pkg::OPC_PD1)      r.length_bytes_left = 3'd1;
        else if (opc == sep_pkg::OPC_PD2) r.length_bytes_left = 3'd2;
        else                              r.length_bytes_left = 3'd4;
        r.len_pos        = 2'd0;
        r.push_remaining = 32'd0;
        r.phase          = next_phase;
        return r;
    endfunction

    state_t      s;
    logic [3:0]  cls;
    logic [31:0] len_word;
    logic [2:0]  code;
    logic        env;

    always_comb begin
        s        = state_reg;
        cls      = sep_pkg::CLS_HEADER;
        len_word = 32'd0;
        code     = sep_pkg::ERR_NONE;
        env      = 1'b0;

        case (state_reg.phase)
            sep_pkg::PH_RET: begin
                s.phase = (script_byte == sep_pkg::OPC_RETURN) ? sep_pkg::PH_MOP
                                                               : sep_pkg::PH_NOT;
            end
            sep_pkg::PH_MOP: begin
                if (script_byte < sep_pkg::OPC_PD1) begin
                    if (script_byte == 8'(sep_pkg::MAGIC_LEN)) begin
                        s.push_remaining = 32'(sep_pkg::MAGIC_LEN);
                        s.magic_shift    = 32'd0;
                        s.phase          = sep_pkg::PH_MDATA;
                    end else begin
                        s.phase = sep_pkg::PH_NOT;
                    end
                end else if (script_byte <= sep_pkg::OPC_PD4) begin
                    s = length_setup(s, script_byte, sep_pkg::PH_MLEN);
                end else begin
                    s.phase = sep_pkg::PH_NOT;
                end
            end
            sep_pkg::PH_MLEN, sep_pkg::PH_LEN: begin
                // little-endian length, one byte a beat
                case (state_reg.len_pos)
                    2'd0:    len_word = {24'd0, script_byte};
                    2'd1:    len_word = {16'd0, script_byte, 8'd0};
                    2'd2:    len_word = {8'd0, script_byte, 16'd0};
                    default: len_word = {script_byte, 24'd0};
                endcase
                s.push_remaining    = state_reg.push_remaining | len_word;
                s.len_pos           = state_reg.len_pos + 2'd1;
                s.length_bytes_left = state_reg.length_bytes_left - 3'd1;
                if (s.length_bytes_left == 3'd0) begin
                    if (state_reg.phase == sep_pkg::PH_MLEN) begin
                        if (s.push_remaining == 32'(sep_pkg::MAGIC_LEN)) begin
                            s.magic_shift = 32'd0;
                            s.phase       = sep_pkg::PH_MDATA;
                        end else begin
                            s.phase = sep_pkg::PH_NOT;
                        end
                    end else begin
                        s = push_begin(s, s.push_remaining, cfg);
                    end
                end
            end
            sep_pkg::PH_MDATA: begin
                s.magic_shift    = {state_reg.magic_shift[23:0], script_byte};
                s.push_remaining = state_reg.push_remaining - 32'd1;
                if (s.push_remaining == 32'd0) begin
                    s.phase = (s.magic_shift == cfg.magic_word) ? sep_pkg::PH_OP
                                                                 : sep_pkg::PH_NOT;
                end
            end
            sep_pkg::PH_OP: begin
                if (script_byte < sep_pkg::OPC_PD1) begin
                    s = push_begin(s, {24'd0, script_byte}, cfg);
                end else if (script_byte <= sep_pkg::OPC_PD4) begin
                    s = length_setup(s, script_byte, sep_pkg::PH_LEN);
                end else begin
                    s.malformed_flag = 1'b1;
                    s.phase          = sep_pkg::PH_BAD;
                end
            end
            sep_pkg::PH_DATA: begin
                cls = state_reg.current_class;
                if (state_reg.first_data && !state_reg.in_body && !state_reg.push_index_odd) begin
                    s.current_tag[7:0] = script_byte;
                end
                s.first_data     = 1'b0;
                s.push_remaining = state_reg.push_remaining - 32'd1;
                if (s.push_remaining == 32'd0) begin
                    s       = push_finish(s, cfg);
                    s.phase = sep_pkg::PH_OP;
                end
            end
            default: begin
                s = state_reg;
            end
        endcase

        env = s.phase inside {[sep_pkg::PH_OP:sep_pkg::PH_BAD]};
        if (!env) code = sep_pkg::ERR_NOT_ENV;
        else if (s.malformed_flag || s.phase != sep_pkg::PH_OP) code = sep_pkg::ERR_MALFORMED;
        else if (!s.in_body && s.push_index_odd) code = sep_pkg::ERR_INCOMPLETE;
        else code = s.first_field_error;

        result.echo_byte      = script_byte;
        result.byte_class     = cls;
        result.script_done    = last_byte;
        result.env_found      = last_byte & env;
        result.envelope_valid = last_byte & env & (code == sep_pkg::ERR_NONE);
        result.error_code     = last_byte ? code : sep_pkg::ERR_NONE;
        result.body_seen      = last_byte & env & (code != sep_pkg::ERR_MALFORMED) & s.in_body;
        result.parent_count   = last_byte ? s.parents_seen : 8'd0;

        // a new script starts after the final byte
        state_next = last_byte ? '0 : s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/sep_out_reg.sv
module sep_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sep_pkg::sep_result_t in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sep_pkg::sep_result_t out_result
);

    logic                 valid_reg;
    sep_pkg::sep_result_t data_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

endmodule

>>> src/script_envelope_parser_top.sv
// script envelope parser
// input channel (s_): one script byte a beat, s_last_byte marks the final byte
// of a script; the next beat after it starts a new script
// result channel (m_): one beat for every input beat, the byte echoed with the
// class of the field it belongs to; on the final byte script_done is high and
// the status fields (envelope, valid, error, body, parent count) are filled in,
// otherwise they are zero
// configuration: cfg_we writes cfg_data into register cfg_index (0 magic word,
// 1..7 tag bytes); write only while no beat is in flight
// latency: a result appears one cycle after its byte is accepted
// throughput: one byte per cycle, set by the single parser state update that
// each byte makes between the input handshake and the result register
// receiver stall: the result register holds its beat and s_ready drops only
// while that register is full and m_ready is low
// reset (aresetn low, synchronous): parser state cleared, result register
// emptied, registers back to their default magic word and tags
module script_envelope_parser_top #(
    parameter int unsigned PARENT_LEN = sep_pkg::PARENT_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_script_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_echo_byte,
    output logic [3:0]  m_byte_class,
    output logic        m_script_done,
    output logic        m_env_found,
    output logic        m_envelope_valid,
    output logic [2:0]  m_error_code,
    output logic        m_body_seen,
    output logic [7:0]  m_parent_count
);

    sep_pkg::sep_cfg_t    cfg;
    sep_pkg::sep_result_t parse_result;
    sep_pkg::sep_result_t out_result;
    logic                 accept;

    // a beat is taken whenever the result register can take its result
    assign accept = s_valid && s_ready;

    sep_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // parser state advances once per accepted beat
    sep_parser #(
        .PARENT_LEN (PARENT_LEN)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .script_byte (s_script_byte),
        .last_byte   (s_last_byte),
        .cfg         (cfg),
        .result      (parse_result)
    );

    // result register, parts the two sides of the block
    sep_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_result  (parse_result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (out_result)
    );

    assign m_echo_byte      = out_result.echo_byte;
    assign m_byte_class     = out_result.byte_class;
    assign m_script_done    = out_result.script_done;
    assign m_env_found      = out_result.env_found;
    assign m_envelope_valid = out_result.envelope_valid;
    assign m_error_code     = out_result.error_code;
    assign m_body_seen      = out_result.body_seen;
    assign m_parent_count   = out_result.parent_count;

endmodule
